[rtl/mps_pkg.sv]
// shared constants, types and helpers for the macro playback sequencer
package mps_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int STEP_DEPTH = 256;

    localparam int SLOT_W   = 3;
    localparam int STEP_W   = 8;
    localparam int LEN_W    = 8;
    localparam int PAGE_W   = 8;
    localparam int USAGE_W  = 16;
    localparam int MODS_W   = 8;
    localparam int DELAY_W  = 16;
    localparam int TAP_W    = 16;

    localparam int STORE_DEPTH = SLOT_COUNT * STEP_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    localparam logic [TAP_W-1:0]  TAP_RESET     = TAP_W'(20);
    localparam logic [PAGE_W-1:0] PAGE_KEYBOARD = 8'h07;
    localparam logic [PAGE_W-1:0] PAGE_CONSUMER = 8'h0c;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_LENGTH  = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [MODS_W-1:0]  mods;
        logic [USAGE_W-1:0] usage;
        logic [PAGE_W-1:0]  page;
    } step_entry_t;

    function automatic logic usage_ok(input logic [PAGE_W-1:0] page,
                                      input logic [USAGE_W-1:0] usage);
        logic ok;
        ok = 1'b0;
        if (usage != '0) begin
            if (page == PAGE_KEYBOARD) begin
                ok = (usage <= USAGE_W'(16'h00ff));
            end else if (page == PAGE_CONSUMER) begin
                ok = (usage <= USAGE_W'(16'h0fff));
            end
        end
        return ok;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [STEP_W-1:0] step);
        return ADDR_W'(ADDR_W'(slot) * ADDR_W'(STEP_DEPTH)) + ADDR_W'(step);
    endfunction

endpackage

[rtl/macro_playback_sequencer_top.sv]
// Keyboard macro playback sequencer: a step store, per-slot lengths, a slot
// queue and a tick-driven press/release worker. Every input word gives exactly
// one result word. A word passes through an input register and a result
// register, and a new word is taken every cycle while results are taken; the
// step store is read ahead into a register from the state each word leaves.
// After reset the step store is cleared one entry per cycle through all
// SLOT_COUNT * STEP_DEPTH (1536) entries, while s_tready stays low; tap_ticks
// writes are taken at any time.
module macro_playback_sequencer_top
    import mps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // macro_slot, step_index, new_length, page_in, usage_in, mods_in, delay_in
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // event_valid, page_out, usage_out, mods_out, accepted, busy_res
    output logic [M_TDATA_W-1:0]  m_tdata,
    // is_press
    output logic [M_TUSER_W-1:0]  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TAP_W-1:0]      cfg_data
);

    // input register
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [SLOT_W-1:0]   in_slot_reg;
    logic [STEP_W-1:0]   in_step_reg;
    logic [LEN_W-1:0]    in_len_reg;
    step_entry_t         in_entry_reg;

    // result register
    logic                out_valid_reg;
    logic                out_event_reg;
    logic                out_press_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [USAGE_W-1:0]  out_usage_reg;
    logic [MODS_W-1:0]   out_mods_reg;
    logic                out_acc_reg;
    logic                out_busy_reg;

    // configuration and state
    logic [TAP_W-1:0]    tap_reg;
    logic [LEN_W-1:0]    len_reg [SLOT_COUNT];
    logic [SLOT_W-1:0]   fifo_reg [SLOT_COUNT];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                running_reg, running_next;
    logic                releasing_reg, releasing_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [DELAY_W-1:0]  wait_reg, wait_next;
    logic                pending_reg, pending_next;

    // step store and its clearing pass
    step_entry_t         store_mem [STORE_DEPTH];
    step_entry_t         rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                clr_active_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    logic                out_free;
    logic                proc;
    logic                busy;
    logic                slot_ok;
    logic                step_ok;
    logic                trig_nz;
    logic [LEN_W-1:0]    front_len;
    logic [SLOT_W-1:0]   front_next;
    logic [LEN_W-1:0]    sat_len;
    logic                enq, deq;
    logic                st_wr, len_wr;
    logic                ev, press, acc;

    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && out_free;
    assign s_tready  = !clr_active_reg && (!in_valid_reg || out_free);
    assign cfg_ready = 1'b1;

    assign busy    = running_reg || pending_reg;
    assign slot_ok = ({1'b0, in_slot_reg} < (SLOT_W + 1)'(SLOT_COUNT));
    assign step_ok = ({1'b0, in_step_reg} < (STEP_W + 1)'(STEP_DEPTH));
    assign sat_len = ({1'b0, in_len_reg} > (LEN_W + 1)'(STEP_DEPTH)) ?
                     LEN_W'(STEP_DEPTH) : in_len_reg;

    always_comb begin
        trig_nz   = 1'b0;
        front_len = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (in_slot_reg == SLOT_W'(i)) begin
                trig_nz = (len_reg[i] != '0);
            end
            if (fifo_reg[0] == SLOT_W'(i)) begin
                front_len = len_reg[i];
            end
        end
    end

    always_comb begin
        logic               rel_eff;
        logic [STEP_W-1:0]  step_eff;
        logic [STEP_W-1:0]  step_inc;
        logic [LEN_W-1:0]   len_eff;
        logic [DELAY_W-1:0] wait_dec;
        logic               act;

        count_next     = count_reg;
        running_next   = running_reg;
        releasing_next = releasing_reg;
        cur_slot_next  = cur_slot_reg;
        step_next      = step_reg;
        cur_len_next   = cur_len_reg;
        wait_next      = wait_reg;
        pending_next   = pending_reg;
        enq = 1'b0;
        deq = 1'b0;
        st_wr = 1'b0;
        len_wr = 1'b0;
        ev = 1'b0;
        press = 1'b0;
        acc = 1'b0;
        rel_eff  = releasing_reg;
        step_eff = step_reg;
        len_eff  = cur_len_reg;
        act      = 1'b0;
        wait_dec = (wait_reg != '0) ? wait_reg - DELAY_W'(1) : '0;
        step_inc = '0;

        if (proc) begin
            case (in_op_reg)
                OP_LOAD: begin
                    if (!busy && slot_ok && step_ok &&
                        usage_ok(in_entry_reg.page, in_entry_reg.usage)) begin
                        st_wr = 1'b1;
                        acc   = 1'b1;
                    end
                end
                OP_LENGTH: begin
                    if (!busy && slot_ok) begin
                        len_wr = 1'b1;
                        acc    = 1'b1;
                    end
                end
                OP_TRIGGER: begin
                    if (slot_ok && trig_nz && (count_reg < CNT_W'(SLOT_COUNT))) begin
                        enq        = 1'b1;
                        acc        = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (!pending_reg) begin
                            pending_next = 1'b1;
                            wait_next    = '0;
                        end
                    end
                end
                OP_TICK: begin
                    if (pending_reg) begin
                        wait_next = wait_dec;
                        if (wait_dec == '0) begin
                            if (running_reg) begin
                                act = 1'b1;
                            end else if (count_reg != '0) begin
                                deq           = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                                cur_slot_next = fifo_reg[0];
                                cur_len_next  = front_len;
                                running_next  = 1'b1;
                                rel_eff       = 1'b0;
                                step_eff      = '0;
                                len_eff       = front_len;
                                act           = 1'b1;
                            end else begin
                                pending_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (act) begin
            ev           = 1'b1;
            press        = !rel_eff;
            pending_next = 1'b1;
            if (!rel_eff) begin
                releasing_next = 1'b1;
                step_next      = step_eff;
                wait_next      = tap_reg;
            end else begin
                step_inc       = step_eff + STEP_W'(1);
                releasing_next = 1'b0;
                step_next      = step_inc;
                if ((step_inc >= len_eff) || (step_inc == '0)) begin
                    running_next = 1'b0;
                end
                wait_next = rd_data_reg.delay;
            end
        end
    end

    // next front of the slot queue, for reading a dequeued macro's first step ahead
    always_comb begin
        if (deq) begin
            front_next = fifo_reg[1 % SLOT_COUNT];
        end else if (enq && (count_reg == '0)) begin
            front_next = in_slot_reg;
        end else begin
            front_next = fifo_reg[0];
        end
    end

    assign rd_addr = running_next ? store_addr(cur_slot_next, step_next) :
                                    store_addr(front_next, '0);

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (st_wr) begin
            store_mem[store_addr(in_slot_reg, in_step_reg)] <= in_entry_reg;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // slot queue, front at entry zero
    always_ff @(posedge aclk) begin
        if (deq) begin
            for (int i = 0; i < SLOT_COUNT - 1; i++) begin
                fifo_reg[i] <= fifo_reg[(i + 1) % SLOT_COUNT];
            end
        end
        if (enq) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (count_reg == CNT_W'(i)) begin
                    fifo_reg[i] <= in_slot_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                len_reg[i] <= '0;
            end
            tap_reg       <= TAP_RESET;
            count_reg     <= '0;
            running_reg   <= 1'b0;
            releasing_reg <= 1'b0;
            cur_slot_reg  <= '0;
            step_reg      <= '0;
            cur_len_reg   <= '0;
            wait_reg      <= '0;
            pending_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tap_reg <= cfg_data;
            end
            if (len_wr) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (in_slot_reg == SLOT_W'(i)) begin
                        len_reg[i] <= sat_len;
                    end
                end
            end
            count_reg     <= count_next;
            running_reg   <= running_next;
            releasing_reg <= releasing_next;
            cur_slot_reg  <= cur_slot_next;
            step_reg      <= step_next;
            cur_len_reg   <= cur_len_next;
            wait_reg      <= wait_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg          <= op_t'(s_tuser[1:0]);
            in_slot_reg        <= s_tdata[2:0];
            in_step_reg        <= s_tdata[10:3];
            in_len_reg         <= s_tdata[18:11];
            in_entry_reg.page  <= s_tdata[26:19];
            in_entry_reg.usage <= s_tdata[42:27];
            in_entry_reg.mods  <= s_tdata[50:43];
            in_entry_reg.delay <= s_tdata[66:51];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_event_reg <= ev;
            out_press_reg <= press;
            out_page_reg  <= ev ? rd_data_reg.page  : '0;
            out_usage_reg <= ev ? rd_data_reg.usage : '0;
            out_mods_reg  <= ev ? rd_data_reg.mods  : '0;
            out_acc_reg   <= acc;
            out_busy_reg  <= running_next || pending_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_busy_reg, out_acc_reg, out_mods_reg, out_usage_reg,
                       out_page_reg, out_event_reg};
    assign m_tuser  = out_press_reg;

    // no word taken while the step store is being cleared
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_tready)
        else $error("input taken during store clear");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOT_COUNT))
        else $error("slot queue overfilled");

    a_running_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> pending_reg)
        else $error("macro running without pending worker");

    a_release_running: assert property (@(posedge aclk) disable iff (!aresetn)
        releasing_reg |-> running_reg)
        else $error("release due with no macro running");

    a_event_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_event_reg) |-> out_busy_reg)
        else $error("key event reported while idle");

endmodule

[dv/tb_macro_playback_sequencer_top.sv]
// testbench for the macro playback sequencer: stream words in, predicted key events checked out
`timescale 1ns / 1ps

module tb_macro_playback_sequencer_top;
    import mps_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_WORDS = 1200;

    typedef struct {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [STEP_W-1:0]  step;
        logic [LEN_W-1:0]   len;
        logic [PAGE_W-1:0]  page;
        logic [USAGE_W-1:0] usage;
        logic [MODS_W-1:0]  mods;
        logic [DELAY_W-1:0] delay;
    } seq_word_t;

    typedef struct {
        logic               event_valid;
        logic               is_press;
        logic [PAGE_W-1:0]  page;
        logic [USAGE_W-1:0] usage;
        logic [MODS_W-1:0]  mods;
        logic               accepted;
        logic               busy;
    } key_result_t;

    class key_event_board;
        step_entry_t        steps[STORE_DEPTH];
        logic [LEN_W-1:0]   lengths[SLOT_COUNT];
        logic [SLOT_W-1:0]  queued[SLOT_COUNT];
        int                 head;
        int                 count;
        bit                 running;
        bit                 releasing;
        int                 cur_slot;
        logic [STEP_W-1:0]  pos;
        int                 wait_left;
        bit                 pending;
        logic [TAP_W-1:0]   tap;
        key_result_t        awaited[$];
        int                 errors;

        function new();
            foreach (steps[i]) steps[i] = '0;
            foreach (lengths[i]) lengths[i] = '0;
            foreach (queued[i]) queued[i] = '0;
            head = 0;
            count = 0;
            running = 0;
            releasing = 0;
            cur_slot = 0;
            pos = '0;
            wait_left = 0;
            pending = 0;
            tap = TAP_RESET;
            errors = 0;
        endfunction

        function bit usage_valid(logic [PAGE_W-1:0] page, logic [USAGE_W-1:0] usage);
            bit ok;
            ok = 0;
            if (usage != 0 && page == PAGE_KEYBOARD) begin
                ok = usage <= 16'h00ff;
            end else if (usage != 0 && page == PAGE_CONSUMER) begin
                ok = usage <= 16'h0fff;
            end
            return ok;
        endfunction

        // one worker action: pick up a queued macro if needed, then press or release, or go idle if none is left
        function key_result_t play_next();
            key_result_t r;
            step_entry_t e;
            logic [SLOT_W-1:0] s;
            r = '{default: 0};
            while (!running && count > 0) begin
                s = queued[head];
                head = (head + 1) % SLOT_COUNT;
                count--;
                cur_slot = (s < SLOT_COUNT) ? int'(s) : 0;
                pos = '0;
                releasing = 0;
                running = lengths[cur_slot] != 0;
            end
            if (!running) begin
                pending = 0;
            end else begin
                e = steps[cur_slot * STEP_DEPTH + int'(pos)];
                r.event_valid = 1'b1;
                r.is_press = !releasing;
                r.page = e.page;
                r.usage = e.usage;
                r.mods = e.mods;
                if (!releasing) begin
                    releasing = 1;
                    wait_left = tap;
                end else begin
                    releasing = 0;
                    pos = pos + 1'b1;
                    if (pos >= lengths[cur_slot] || pos == 0) running = 0;
                    wait_left = e.delay;
                end
                pending = 1;
            end
            return r;
        endfunction

        function void note_word(seq_word_t w);
            key_result_t r;
            bit idle;
            r = '{default: 0};
            idle = !running && !pending;
            case (w.op)
                OP_LOAD: begin
                    if (idle && w.slot < SLOT_COUNT && usage_valid(w.page, w.usage)) begin
                        steps[int'(w.slot) * STEP_DEPTH + int'(w.step)] =
                            '{delay: w.delay, mods: w.mods, usage: w.usage, page: w.page};
                        r.accepted = 1'b1;
                    end
                end
                OP_LENGTH: begin
                    if (idle && w.slot < SLOT_COUNT) begin
                        lengths[w.slot] = w.len;
                        r.accepted = 1'b1;
                    end
                end
                OP_TRIGGER: begin
                    if (w.slot < SLOT_COUNT && lengths[w.slot] != 0 && count < SLOT_COUNT) begin
                        queued[(head + count) % SLOT_COUNT] = w.slot;
                        count++;
                        r.accepted = 1'b1;
                        if (!pending) begin
                            pending = 1;
                            wait_left = 0;
                        end
                    end
                end
                default: begin
                    if (pending) begin
                        if (wait_left > 0) wait_left--;
                        if (wait_left == 0) r = play_next();
                    end
                end
            endcase
            r.busy = running || pending;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] d, logic press);
            key_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h", $time, d);
                errors++;
            end else begin
                want = awaited.pop_front();
                compare_field("event_valid", want.event_valid, d[0]);
                compare_field("is_press", want.is_press, press);
                compare_field("page_out", want.page, d[8:1]);
                compare_field("usage_out", want.usage, d[24:9]);
                compare_field("mods_out", want.mods, d[32:25]);
                compare_field("accepted", want.accepted, d[33]);
                compare_field("busy_res", want.busy, d[34]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TAP_W-1:0]     cfg_data;

    key_event_board board;
    bit             calm = 0;
    bit             burst = 0;
    int             hold_off = 0;
    int             cycles = 0;
    int             words_sent = 0;

    macro_playback_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    initial m_tready = 1'b0;
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && !burst && $urandom_range(0, 99) < 20) hold_off <= idle_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("macro_playback_sequencer_top verification failed");
            $finish;
        end
    end

    task automatic send_word(seq_word_t w);
        int gap;
        gap = (calm || burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({w.delay, w.mods, w.usage, w.page, w.len, w.step, w.slot});
        s_tuser  <= w.op;
        do @(posedge aclk); while (!s_tready);
        board.note_word(w);
        words_sent++;
    endtask

    function automatic seq_word_t make_word(op_t op, int slot, int step, int len, int page,
                                            int usage, int mods, int delay);
        seq_word_t w;
        w.op = op;
        w.slot = SLOT_W'(slot);
        w.step = STEP_W'(step);
        w.len = LEN_W'(len);
        w.page = PAGE_W'(page);
        w.usage = USAGE_W'(usage);
        w.mods = MODS_W'(mods);
        w.delay = DELAY_W'(delay);
        return w;
    endfunction

    // full-range content; large delays only at the last step, which no length can reach
    function automatic seq_word_t noise_word(op_t op);
        seq_word_t w;
        w.op = op;
        w.slot = SLOT_W'($urandom_range(0, 7));
        w.step = ($urandom_range(0, 7) == 0) ? 8'hff : STEP_W'($urandom);
        w.len = LEN_W'($urandom_range(0, 8));
        w.page = ($urandom_range(0, 2) == 0) ? PAGE_W'($urandom) :
                 ($urandom_range(0, 1) ? PAGE_CONSUMER : PAGE_KEYBOARD);
        w.usage = $urandom_range(0, 1) ? USAGE_W'($urandom) : USAGE_W'($urandom_range(0, 300));
        w.mods = MODS_W'($urandom);
        w.delay = (w.step == 8'hff) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 3));
        return w;
    endfunction

    task automatic load_step(int slot, int step, int page, int usage, int mods, int delay);
        send_word(make_word(OP_LOAD, slot, step, 0, page, usage, mods, delay));
    endtask

    task automatic set_length(int slot, int len);
        send_word(make_word(OP_LENGTH, slot, 0, len, 0, 0, 0, 0));
    endtask

    task automatic trigger(int slot);
        send_word(make_word(OP_TRIGGER, slot, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic tick();
        send_word(make_word(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic load_good(int slot, int step);
        bit consumer;
        consumer = ($urandom_range(0, 1) == 1);
        load_step(slot, step, consumer ? PAGE_CONSUMER : PAGE_KEYBOARD,
                  consumer ? $urandom_range(1, 16'h0fff) : $urandom_range(1, 8'hff),
                  $urandom, $urandom_range(0, 3));
    endtask

    task automatic drain_to_idle();
        while (board.running || board.pending) tick();
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.awaited.size() != 0);
    endtask

    task automatic write_tap(logic [TAP_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.tap = value;
    endtask

    task automatic run_directed();
        load_step(0, 0, PAGE_KEYBOARD, 8'hff, 8'hff, 1);
        load_step(0, 1, PAGE_CONSUMER, 16'h0fff, 0, 0);
        load_step(0, 2, PAGE_KEYBOARD, 16'h0100, 0, 0);
        load_step(0, 2, PAGE_CONSUMER, 16'h1000, 0, 0);
        load_step(0, 2, PAGE_KEYBOARD, 0, 0, 0);
        load_step(0, 2, 8'h00, 5, 0, 0);
        load_step(7, 0, PAGE_KEYBOARD, 4, 0, 0);
        load_step(6, 0, PAGE_KEYBOARD, 4, 0, 0);
        load_step(5, 255, PAGE_CONSUMER, 1, 8'ha5, 16'hffff);
        set_length(5, 255);
        set_length(6, 3);
        trigger(1);
        trigger(7);
        set_length(0, 2);
        trigger(0);
        load_step(1, 0, PAGE_KEYBOARD, 4, 0, 0);
        set_length(1, 1);
        tick();
        repeat (7) trigger(0);
        drain_to_idle();
        tick();
        set_length(5, 0);
    endtask

    task automatic session_formed();
        int n_slots;
        int slot;
        int steps_in;
        int r;
        drain_to_idle();
        slot = 0;
        n_slots = $urandom_range(1, 3);
        repeat (n_slots) begin
            slot = $urandom_range(0, SLOT_COUNT - 1);
            steps_in = $urandom_range(1, 6);
            for (int i = 0; i < steps_in; i++) load_good(slot, i);
            if ($urandom_range(0, 3) == 0) send_word(noise_word(OP_LOAD));
            set_length(slot, $urandom_range(1, steps_in));
        end
        repeat ($urandom_range(1, 8)) trigger(($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, 7) : slot);
        repeat ($urandom_range(5, 150)) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                trigger($urandom_range(0, 7));
            end else if (r == 1) begin
                load_good($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, 7));
            end else if (r == 2) begin
                set_length($urandom_range(0, SLOT_COUNT - 1), $urandom_range(1, 6));
            end else begin
                tick();
            end
        end
        if ($urandom_range(0, 7) == 0) wait_for_results();
    endtask

    task automatic session_noise();
        repeat ($urandom_range(5, 25)) send_word(noise_word(op_t'($urandom_range(0, 3))));
    endtask

    initial begin
        logic [TAP_W-1:0] taps[5];
        int base;
        board = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        taps = '{16'd0, 16'd1, 16'd3, 16'd20, 16'd2};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        base = words_sent;
        for (int p = 0; p < 5; p++) begin
            write_tap(taps[p]);
            while (words_sent - base < RANDOM_WORDS * (p + 1) / 5) begin
                calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 4) == 0) session_noise();
                else session_formed();
            end
        end
        calm = 0;

        // long press: tap count past one byte, run without idling
        drain_to_idle();
        write_tap(16'h0100);
        load_step(0, 0, PAGE_KEYBOARD, 8'h04, 0, 2);
        set_length(0, 1);
        trigger(0);
        burst = 1;
        drain_to_idle();
        burst = 0;

        wait_for_results();
        repeat (4) @(posedge aclk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("macro_playback_sequencer_top verification clean");
        end else begin
            $display("macro_playback_sequencer_top verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mps_pkg.sv
rtl/macro_playback_sequencer_top.sv
dv/tb_macro_playback_sequencer_top.sv
